@@ hdl/nkd_pkg.sv @@
// Shared types, constants and NAL type helpers for the keyframe detector.
package nkd_pkg;

  // Field widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned HoldW = 3;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepthDef = 4;

  // Codec select codes.
  localparam logic CodecH264 = 1'b0;
  localparam logic CodecH265 = 1'b1;

  // NAL type field masks.
  localparam logic [7:0] H264TypeMask = 8'h1F;
  localparam logic [5:0] H265TypeMask = 6'h3F;

  // Qualifying H.264 types.
  localparam logic [4:0] H264Idr = 5'd5;
  localparam logic [4:0] H264Sps = 5'd7;
  localparam logic [4:0] H264Pps = 5'd8;

  // Qualifying H.265 type ranges.
  localparam logic [5:0] H265IrapLo  = 6'd19;
  localparam logic [5:0] H265IrapHi  = 6'd21;
  localparam logic [5:0] H265ParmLo  = 6'd32;
  localparam logic [5:0] H265ParmHi  = 6'd34;

  // One event handed from the front part to the back part.
  typedef struct packed {
    logic             hdr_valid;  // beat was a NAL header byte
    logic [ByteW-1:0] hdr;        // the header byte
    logic             four;       // start code had the four-byte form
    logic             last;       // beat closed the frame
    logic             codec;      // codec select when the beat arrived
  } nkd_event_t;

  // H.264: IDR slice, SPS or PPS.
  function automatic logic h264_flags(input logic [ByteW-1:0] hdr);
    logic [4:0] t;
    t = 5'(hdr & H264TypeMask);
    return (t == H264Idr) || (t == H264Sps) || (t == H264Pps);
  endfunction

  // H.265: IRAP types 19 to 21 and VPS/SPS/PPS.
  function automatic logic h265_flags(input logic [ByteW-1:0] hdr);
    logic [5:0] t;
    t = 6'(hdr >> 1) & H265TypeMask;
    return ((t >= H265IrapLo) && (t <= H265IrapHi)) ||
           ((t >= H265ParmLo) && (t <= H265ParmHi));
  endfunction

endpackage

@@ hdl/nkd_front.sv @@
// Front part: takes byte beats, finds start codes and emits header and frame-end events.
module nkd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       codec_sel,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [nkd_pkg::ByteW-1:0]  in_data_byte,
  input  logic                       in_last_byte,
  input  logic                       q_full,
  output logic                       q_push,
  output nkd_pkg::nkd_event_t        q_event
);
  import nkd_pkg::*;

  logic [ByteW-1:0] recent_r   [4];
  logic [ByteW-1:0] recent_nxt [4];
  logic [HoldW-1:0] hold_r, hold_nxt;
  logic             accept;
  logic             is_header;
  logic             four;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Start code check over the bytes held in the search window.
  assign is_header = (hold_r >= HoldW'(3)) && (recent_r[2] == '0) &&
                     (recent_r[1] == '0) && (recent_r[0] == ByteW'(1));
  assign four      = (hold_r >= HoldW'(4)) && (recent_r[3] == '0);

  // Only header bytes and frame ends go to the back part.
  assign q_push            = accept && (is_header || in_last_byte);
  assign q_event.hdr_valid = is_header;
  assign q_event.hdr       = in_data_byte;
  assign q_event.four      = four;
  assign q_event.last      = in_last_byte;
  assign q_event.codec     = codec_sel;

  // Byte history and window count update.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      recent_nxt[k] = recent_r[k];
    end
    hold_nxt = hold_r;
    if (accept) begin
      if (in_last_byte) begin
        for (int k = 0; k < 4; k++) begin
          recent_nxt[k] = '0;
        end
        hold_nxt = '0;
      end else begin
        for (int k = 3; k > 0; k--) begin
          recent_nxt[k] = recent_r[k-1];
        end
        recent_nxt[0] = in_data_byte;
        if (is_header) begin
          hold_nxt = '0;
        end else if (hold_r < HoldW'(4)) begin
          hold_nxt = hold_r + HoldW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        recent_r[k] <= '0;
      end
      hold_r <= '0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        recent_r[k] <= recent_nxt[k];
      end
      hold_r <= hold_nxt;
    end
  end

endmodule

@@ hdl/nkd_queue.sv @@
// Short event queue between the front and back parts.
module nkd_queue #(
  parameter int unsigned DEPTH = nkd_pkg::QueueDepthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nkd_pkg::nkd_event_t  push_event,
  input  logic                 pop,
  output nkd_pkg::nkd_event_t  head_event,
  output logic                 empty,
  output logic                 full
);
  import nkd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  nkd_event_t      store_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign empty      = (cnt_r == '0);
  assign full       = (cnt_r == CntW'(DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_event = store_r[rd_ptr_r];

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_event;
    end
  end

endmodule

@@ hdl/nkd_back.sv @@
// Back part: judges header types, tracks the frame flag and drives the result register.
module nkd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nkd_pkg::nkd_event_t  head_event,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_keyframe
);
  import nkd_pkg::*;

  logic found_r, found_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_key_r, out_key_nxt;
  logic slot_free;
  logic counts;

  // A frame end can only leave the queue when the result register has room.
  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = !q_empty && (!head_event.last || slot_free);

  // Header qualification under the codec captured with the beat.
  always_comb begin
    counts = 1'b0;
    if (head_event.hdr_valid) begin
      case (head_event.codec)
        CodecH265: counts = !head_event.last && h265_flags(head_event.hdr);
        CodecH264: counts = (head_event.four || !head_event.last) &&
                            h264_flags(head_event.hdr);
        default:   counts = 1'b0;
      endcase
    end
  end

  // Frame flag and result register.
  always_comb begin
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      if (head_event.last) begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = found_r || counts;
        found_nxt     = 1'b0;
      end else if (counts) begin
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r <= out_key_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_keyframe = out_key_r;

endmodule

@@ hdl/nal_keyframe_detector.sv @@
// Top level of the Annex B keyframe detector.
//
// The input channel carries one frame byte per beat (in_data_byte) with
// in_last_byte set on the final byte of the frame. The output channel gives
// one beat per frame: out_keyframe is high when the frame holds a counted
// keyframe or parameter-set NAL header under the selected codec rules.
// cfg_codec_select is written with cfg_wr_en (0 = H.264, 1 = H.265) and is
// sampled with each header byte.
//
// Throughput is one byte per cycle while the queue has room. The front part
// finds start codes in a four-byte history and queues one event per header
// byte or frame end; the back part retires one event per cycle unless a frame
// end waits on a stalled output register. A frame end waits in the queue behind
// any events ahead of it and then loads the result into the output register.
//
// Reset clears the byte history, the queue, the frame flag and the codec
// select. When the receiver stalls, the result holds in the output register,
// events pile up in the queue, and in_ready drops only once the queue fills.
module nal_keyframe_detector #(
  parameter int unsigned QUEUE_DEPTH = nkd_pkg::QueueDepthDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_codec_select,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [nkd_pkg::ByteW-1:0] in_data_byte,
  input  logic                      in_last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_keyframe
);
  import nkd_pkg::*;

  logic       codec_r;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  nkd_event_t push_event;
  nkd_event_t head_event;

  // Codec select register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= CodecH264;
    end else if (cfg_wr_en) begin
      codec_r <= cfg_codec_select;
    end
  end

  nkd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .codec_sel    (codec_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_event      (push_event)
  );

  nkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_event (push_event),
    .pop        (q_pop),
    .head_event (head_event),
    .empty      (q_empty),
    .full       (q_full)
  );

  nkd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_event   (head_event),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_keyframe (out_keyframe)
  );

endmodule

@@ hdl/nkd_checker.sv @@
// Port-level checks for the keyframe detector, bound to the top level.
module nkd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_keyframe
);

  // Reset leaves no result pending.
  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // Reset empties the queue, so input is taken at once.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_keyframe))
    else $error("result beat changed while stalled");

  // The queue can only fill behind a result waiting in the output register.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held off with no result pending");

endmodule

bind nal_keyframe_detector nkd_checker u_nkd_checker (.*);
